// ----- design/bev_pkg.sv -----
package bev_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ROUND  = 2'd0;
    localparam t_kind KIND_SQUARE = 2'd1;
    localparam t_kind KIND_CURLY  = 2'd2;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LSQR   = 8'h5B;
    localparam logic [7:0] CH_LCURL  = 8'h7B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RSQR   = 8'h5D;
    localparam logic [7:0] CH_RCURL  = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP,
        CLS_DIGIT,
        CLS_OTHER
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        t_kind       kind;
    } t_char_info;

    // one command to every stack cell, shifts the whole chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_cmd;

    function automatic t_char_info classify(input logic [7:0] c);
        t_char_info info;
        info.kind = KIND_ROUND;
        info.cls  = CLS_OTHER;
        unique case (c)
            CH_LPAREN: begin info.cls = CLS_OPEN;  info.kind = KIND_ROUND;  end
            CH_LSQR:   begin info.cls = CLS_OPEN;  info.kind = KIND_SQUARE; end
            CH_LCURL:  begin info.cls = CLS_OPEN;  info.kind = KIND_CURLY;  end
            CH_RPAREN: begin info.cls = CLS_CLOSE; info.kind = KIND_ROUND;  end
            CH_RSQR:   begin info.cls = CLS_CLOSE; info.kind = KIND_SQUARE; end
            CH_RCURL:  begin info.cls = CLS_CLOSE; info.kind = KIND_CURLY;  end
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                info.cls = CLS_OP;
            end
            default: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    info.cls = CLS_DIGIT;
                end
            end
        endcase
        return info;
    endfunction

endpackage

// ----- design/bracket_expression_validator_unit.sv -----
// Bracket expression checker.
// Input channel: one ASCII character per request (i_in_character) with
// i_in_last_char marking the end of an expression; taken when i_in_valid is
// high and o_in_stall is low.
// Output channel: one verdict (o_out_expression_valid) per expression, on the
// request that carried i_in_last_char; taken when o_out_valid is high and
// i_out_stall is low.
// Throughput: one character per cycle while the output side is not stalled.
// Each character reads only the top cell of the bracket stack, a chain of
// STACK_DEPTH cells that all shift in the same cycle, so the per-character
// update is one register stage. The verdict is registered and appears in the
// cycle after the last character is taken. A verdict held by a stalled receiver
// stalls the input side until it is taken; an output register sits between the two sides.
// Reset clears the level count, error, operator and length state and the
// output valid flag; stack cells need no clearing, as only entries pushed within
// the current expression are ever read.
// After each verdict the expression state returns to its reset values.
module bracket_expression_validator_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_character,
    input  logic       i_in_last_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_out_expression_valid
);

    localparam int LW = $clog2(STACK_DEPTH + 1);

    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    logic          r_err;
    logic          n_err;
    logic          r_prev_op;
    logic          n_prev_op;
    logic [1:0]    r_len;
    logic [1:0]    n_len;
    logic          r_out_valid;
    logic          r_out_data;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    bev_pkg::t_char_info  w_info;
    bev_pkg::t_stack_cmd  w_cmd;
    bev_pkg::t_kind       w_kind [STACK_DEPTH];
    logic                 w_verdict;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_info     = bev_pkg::classify(i_in_character);
    assign w_full     = (r_level == LW'(STACK_DEPTH));
    assign w_empty    = (r_level == '0);

    always_comb begin
        w_cmd.push = 1'b0;
        w_cmd.pop  = 1'b0;
        n_level    = r_level;
        n_err      = r_err;
        n_prev_op  = r_prev_op;
        n_len      = r_len;
        if (w_accept) begin
            if (r_len != 2'd3) begin
                n_len = r_len + 2'd1;
            end
            unique case (w_info.cls)
                bev_pkg::CLS_OPEN: begin
                    if (w_full) begin
                        n_err = 1'b1;
                    end else begin
                        w_cmd.push = 1'b1;
                        n_level    = r_level + LW'(1);
                    end
                end
                bev_pkg::CLS_CLOSE: begin
                    if (w_empty || w_kind[0] != w_info.kind) begin
                        n_err = 1'b1;
                    end else begin
                        w_cmd.pop = 1'b1;
                        n_level   = r_level - LW'(1);
                    end
                end
                bev_pkg::CLS_OP: begin
                    if (r_prev_op) begin
                        n_err = 1'b1;
                    end
                end
                bev_pkg::CLS_DIGIT: begin
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
            n_prev_op = (w_info.cls == bev_pkg::CLS_OP);
        end
    end

    assign w_verdict = ~n_err && (n_level == '0) && (n_len == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_err     <= 1'b0;
            r_prev_op <= 1'b0;
            r_len     <= 2'd0;
        end else if (w_accept && i_in_last_char) begin
            r_level   <= '0;
            r_err     <= 1'b0;
            r_prev_op <= 1'b0;
            r_len     <= 2'd0;
        end else begin
            r_level   <= n_level;
            r_err     <= n_err;
            r_prev_op <= n_prev_op;
            r_len     <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_in_last_char) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_last_char) begin
            r_out_data <= w_verdict;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_expression_valid = r_out_data;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        bev_pkg::t_kind w_prev;
        bev_pkg::t_kind w_next;
        if (g == 0) begin : g_top
            assign w_prev = w_info.kind;
        end else begin : g_mid
            assign w_prev = w_kind[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_next = w_kind[g];
        end else begin : g_inner
            assign w_next = w_kind[g+1];
        end
        bev_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_prev_kind (w_prev),
            .i_next_kind (w_next),
            .o_kind      (w_kind[g])
        );
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept && i_in_last_char))
        else $error("verdict without a last character");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last_char) |=>
            (r_level == '0 && !r_err && !r_prev_op && r_len == 2'd0))
        else $error("expression state not cleared");

    a_full_push_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in_last_char && w_full && w_info.cls == bev_pkg::CLS_OPEN)
            |=> (r_err && r_level == LW'(STACK_DEPTH)))
        else $error("push onto full stack not flagged");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_cmd.pop))
        else $error("push and pop together");

endmodule

// ----- design/bev_cell.sv -----
// One stack entry. Push takes the entry above (the new top for cell 0),
// pop takes the entry below.
module bev_cell (
    input  logic                i_clk,
    input  bev_pkg::t_stack_cmd i_cmd,
    input  bev_pkg::t_kind      i_prev_kind,
    input  bev_pkg::t_kind      i_next_kind,
    output bev_pkg::t_kind      o_kind
);

    bev_pkg::t_kind r_kind;
    bev_pkg::t_kind n_kind;

    always_comb begin
        priority if (i_cmd.push) begin
            n_kind = i_prev_kind;
        end else if (i_cmd.pop) begin
            n_kind = i_next_kind;
        end else begin
            n_kind = r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;

endmodule
